FILE: rtl/bsfn_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap set package
// Shared widths, request codes and sequencer states for the bitmap set.
// ----------------------------------------------------------------------------
package bsfn_pkg;

    localparam int ELEM_W   = 12;
    localparam int WORD_W   = 64;
    localparam int BIT_W    = 6;
    localparam int ADDR_W   = ELEM_W - BIT_W;
    localparam int NWORDS   = 1 << ADDR_W;
    localparam int ACT_W    = 2;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_ERASE  = 2'd1,
        ACT_TEST   = 2'd2,
        ACT_FIND   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FOUND,
        ST_RESULT
    } state_t;

endpackage

FILE: rtl/bitmap_set_find_next.sv
// ----------------------------------------------------------------------------
// Bitmap set with find next
// Insert, erase and test pass through the execute and result states; an out
// of range request goes straight to the result state. Find next reads one
// bitmap word per cycle in the execute state until a member or the capacity
// word is reached, then passes through the found state on a hit.
// Throughput: one request at a time; the next is taken once the result
// is in the output register. Reset clears the set and sets capacity 4095.
// ----------------------------------------------------------------------------
module bitmap_set_find_next
    import bsfn_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [ELEM_W-1:0]    cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // element [11:0], zero pad
    input  logic [ACT_W-1:0]     s_tuser,   // action [1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // present [0], position [12:1], zero pad
    output logic                 m_tuser    // status [0]
);

    logic [WORD_W-1:0] mem [NWORDS];
    logic [NWORDS-1:0] vld_reg;
    logic [WORD_W-1:0] rdata_reg;
    logic              rvld_reg;
    logic              mem_we;
    logic [WORD_W-1:0] mem_wdata;

    state_t            state_reg, state_next;
    logic [ELEM_W-1:0] cap_reg;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    action_t           act_reg, act_next;
    logic              first_reg, first_next;
    logic [WORD_W-1:0] bits_reg, bits_next;
    logic              status_reg, status_next;
    logic              present_reg, present_next;
    logic [ELEM_W-1:0] pos_reg, pos_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic              m_tuser_reg, m_tuser_next;

    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] masked;
    logic [WORD_W-1:0] iso;
    logic [BIT_W-1:0]  low_idx;
    logic [ELEM_W-1:0] in_elem;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign in_elem   = s_tdata[ELEM_W-1:0];

    assign word = rvld_reg ? rdata_reg : '0;

    always_comb begin
        logic [WORD_W-1:0] lo_mask;
        logic [WORD_W-1:0] hi_mask;
        lo_mask = first_reg ? ({WORD_W{1'b1}} << bit_reg) : {WORD_W{1'b1}};
        hi_mask = (addr_reg == cap_reg[ELEM_W-1:BIT_W])
                ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - cap_reg[BIT_W-1:0]))
                : {WORD_W{1'b1}};
        masked  = word & lo_mask & hi_mask;
    end

    assign iso = bits_reg & (~bits_reg + WORD_W'(1));

    always_comb begin
        low_idx = '0;
        for (int j = 0; j < BIT_W; j++) begin
            for (int i = 0; i < WORD_W; i++) begin
                if (((i >> j) & 1) == 1) begin
                    low_idx[j] = low_idx[j] | iso[i];
                end
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        bit_next      = bit_reg;
        act_next      = act_reg;
        first_next    = first_reg;
        bits_next     = bits_reg;
        status_next   = status_reg;
        present_next  = present_reg;
        pos_next      = pos_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        mem_we        = 1'b0;
        mem_wdata     = word;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    act_next     = action_t'(s_tuser);
                    addr_next    = in_elem[ELEM_W-1:BIT_W];
                    bit_next     = in_elem[BIT_W-1:0];
                    first_next   = 1'b1;
                    status_next  = 1'b0;
                    present_next = 1'b0;
                    pos_next     = '0;
                    if (in_elem > cap_reg) begin
                        status_next = 1'b1;
                        state_next  = ST_RESULT;
                    end else begin
                        state_next  = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                case (act_reg)
                    ACT_INSERT: begin
                        mem_we     = 1'b1;
                        mem_wdata  = word | (WORD_W'(1) << bit_reg);
                        state_next = ST_RESULT;
                    end
                    ACT_ERASE: begin
                        mem_we     = 1'b1;
                        mem_wdata  = word & ~(WORD_W'(1) << bit_reg);
                        state_next = ST_RESULT;
                    end
                    ACT_TEST: begin
                        present_next = word[bit_reg];
                        state_next   = ST_RESULT;
                    end
                    default: begin
                        first_next = 1'b0;
                        if (|masked) begin
                            bits_next  = masked;
                            state_next = ST_FOUND;
                        end else if (addr_reg == cap_reg[ELEM_W-1:BIT_W]) begin
                            state_next = ST_RESULT;
                        end else begin
                            addr_next = addr_reg + ADDR_W'(1);
                        end
                    end
                endcase
            end
            ST_FOUND: begin
                present_next = 1'b1;
                pos_next     = {addr_reg, low_idx};
                state_next   = ST_RESULT;
            end
            ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(M_DATA_W - ELEM_W - 1){1'b0}}, pos_reg, present_reg};
                    m_tuser_next  = status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg      <= {ELEM_W{1'b1}};
            m_tvalid_reg <= 1'b0;
            vld_reg      <= '0;
        end else begin
            if (cfg_valid) begin
                cap_reg <= cfg_data;
            end
            m_tvalid_reg <= m_tvalid_next;
            if (mem_we) begin
                vld_reg[addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg    <= addr_next;
        bit_reg     <= bit_next;
        act_reg     <= act_next;
        first_reg   <= first_next;
        bits_reg    <= bits_next;
        status_reg  <= status_next;
        present_reg <= present_next;
        pos_reg     <= pos_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        rvld_reg    <= vld_reg[addr_next];
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[addr_reg] <= mem_wdata;
        end
        rdata_reg <= mem[addr_next];
    end

endmodule

FILE: rtl/bsfn_checker.sv
// ----------------------------------------------------------------------------
// Bitmap set port checker
// Checks result encoding and request handling seen at the top level ports.
// ----------------------------------------------------------------------------
module bsfn_checker
    import bsfn_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_DATA_W-1:0]  m_tdata,
    input logic                 m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Result changed while stalled.");

    a_range_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("Out of range result carries data.");

    a_absent_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[ELEM_W:1] == '0)
        else $error("Nonzero position without a member.");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Request taken while busy.");

endmodule

bind bitmap_set_find_next bsfn_checker u_bsfn_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bitmap set with find next testbench
// Sends insert, erase, membership and find-next requests to the bitmap set
// under several capacity settings, predicts each result from a private copy
// of the set, and compares every result field against that prediction.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic        status;
    logic        present;
    logic [11:0] position;
} set_result_t;

class bitmap_scoreboard;
    logic [63:0] words [64];
    logic [11:0] capacity;
    set_result_t expected_q [$];
    int errors;
    int checked;
    int hits;

    function new();
        foreach (words[i]) words[i] = '0;
        capacity = 12'd4095;
        errors = 0;
        checked = 0;
        hits = 0;
    endfunction

    function void set_capacity(logic [11:0] value);
        capacity = value;
    endfunction

    function void note_request(bsfn_pkg::action_t act, logic [11:0] elem);
        set_result_t r;
        int p;
        r = '0;
        if (elem > capacity) begin
            r.status = 1'b1;
        end else begin
            case (act)
                bsfn_pkg::ACT_INSERT: words[elem[11:6]][elem[5:0]] = 1'b1;
                bsfn_pkg::ACT_ERASE:  words[elem[11:6]][elem[5:0]] = 1'b0;
                bsfn_pkg::ACT_TEST:   r.present = words[elem[11:6]][elem[5:0]];
                default: begin
                    for (p = elem; p <= capacity; p++) begin
                        if (words[p / 64][p % 64]) begin
                            r.present = 1'b1;
                            r.position = p[11:0];
                            break;
                        end
                    end
                    if (r.present) hits++;
                end
            endcase
        end
        expected_q.push_back(r);
    endfunction

    function void check_result(set_result_t got);
        set_result_t want;
        checked++;
        if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, actual status %0d present %0d position %0d",
                     $time, got.status, got.present, got.position);
            return;
        end
        want = expected_q.pop_front();
        if (got.status !== want.status || got.present !== want.present ||
            got.position !== want.position) begin
            errors++;
            $display("%0t: mismatch, expected status %0d present %0d position %0d, %s",
                     $time, want.status, want.present, want.position, "actual below");
            $display("%0t:           actual   status %0d present %0d position %0d",
                     $time, got.status, got.present, got.position);
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module tb_top;
    import bsfn_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [ELEM_W-1:0]   cfg_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;   // element [11:0], zero pad
    logic [ACT_W-1:0]    s_tuser = '0;   // action [1:0]
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;        // present [0], position [12:1], zero pad
    logic                m_tuser;        // status [0]

    bitmap_scoreboard sb = new();
    int  cycles = 0;
    int  sent = 0;
    int  cfg_writes = 0;
    bit  quiet = 1'b0;
    bit  pressure_req = 1'b0;
    int  hold_left = 0;

    bitmap_set_find_next dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results pending", cycles, sb.pending());
            $display("bitmap_set_find_next verification failed");
            $finish;
        end
    end

    // Result side: checks each accepted result and decides when to stall.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result({m_tuser, m_tdata[0], m_tdata[12:1]});
        end
        if (pressure_req) begin
            pressure_req = 1'b0;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet || ($urandom_range(99) >= 23);
        end
    end

    task automatic push_request(input action_t act, input logic [11:0] elem);
        while (!quiet && $urandom_range(99) < 23) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, elem};
        s_tuser  <= act;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(act, elem);
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [11:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.set_capacity(value);
        cfg_writes++;
    endtask

    function automatic logic [11:0] pick_element(int base, int cap);
        int r;
        int v;
        r = $urandom_range(99);
        if (r < 45) begin
            v = base + $urandom_range(191);
        end else if (r < 60) begin
            v = $urandom_range(4095);
        end else if (r < 80) begin
            v = cap + $urandom_range(6) - 3;
        end else begin
            v = $urandom_range(63) * 64 + ($urandom_range(1) ? 63 : 0);
        end
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v[11:0];
    endfunction

    function automatic action_t pick_action();
        int r;
        r = $urandom_range(99);
        if (r < 35) return ACT_INSERT;
        if (r < 55) return ACT_ERASE;
        if (r < 75) return ACT_TEST;
        return ACT_FIND;
    endfunction

    initial begin
        int caps [8];
        int base;
        int count;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty set, both ends of the range, repeats and word boundaries.
        write_capacity(12'd4095);
        push_request(ACT_FIND, 12'd0);
        push_request(ACT_INSERT, 12'd0);
        push_request(ACT_INSERT, 12'd4095);
        push_request(ACT_INSERT, 12'd4095);
        push_request(ACT_TEST, 12'd0);
        push_request(ACT_TEST, 12'd4095);
        push_request(ACT_TEST, 12'd1);
        push_request(ACT_FIND, 12'd0);
        push_request(ACT_FIND, 12'd1);
        push_request(ACT_FIND, 12'd4095);
        push_request(ACT_INSERT, 12'd63);
        push_request(ACT_INSERT, 12'd64);
        push_request(ACT_FIND, 12'd1);
        push_request(ACT_ERASE, 12'd63);
        push_request(ACT_ERASE, 12'd63);
        push_request(ACT_FIND, 12'd1);
        push_request(ACT_TEST, 12'd63);

        // A lowered capacity hides the member stored at the top.
        write_capacity(12'd100);
        push_request(ACT_TEST, 12'd4095);
        push_request(ACT_INSERT, 12'd101);
        push_request(ACT_FIND, 12'd65);
        push_request(ACT_ERASE, 12'd100);
        push_request(ACT_FIND, 12'd64);
        push_request(ACT_FIND, 12'd3000);

        write_capacity(12'd0);
        push_request(ACT_INSERT, 12'd0);
        push_request(ACT_FIND, 12'd0);
        push_request(ACT_TEST, 12'd1);
        push_request(ACT_FIND, 12'd1);

        caps = '{4095, 0, 63, 64, 0, 0, 4095, 4094};
        caps[1] = $urandom_range(4095);
        caps[5] = $urandom_range(4095);
        for (int ph = 0; ph < 8; ph++) begin
            write_capacity(caps[ph][11:0]);
            quiet = (ph == 6);
            base = ($urandom_range(caps[ph]) / 64) * 64;
            count = (ph == 4) ? 40 : 160;
            for (int i = 0; i < count; i++) begin
                if (ph == 0 && i == 30) pressure_req = 1'b1;
                push_request(pick_action(), pick_element(base, caps[ph]));
            end
        end
        quiet = 1'b0;

        drain();
        repeat (80) @(posedge aclk);
        $display("Sent %0d requests over %0d capacity settings; %0d results checked,",
                 sent, cfg_writes, sb.checked);
        $display("%0d find-next requests located a member.", sb.hits);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("bitmap_set_find_next verification clean");
        end else begin
            $display("%0d errors, %0d results never arrived", sb.errors, sb.pending());
            $display("bitmap_set_find_next verification failed");
        end
        $finish;
    end
endmodule
